FILE: src/ctf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Complementary tilt filter package
// Shared constants, register indexes, sequencer states and arctangent table.
// ----------------------------------------------------------------------------
package ctf_pkg;

  localparam int unsigned ARCTAN_STEPS = 16;
  localparam int unsigned TABLE_LEN    = 24;
  localparam int unsigned CORDIC_STEPS = (ARCTAN_STEPS < TABLE_LEN) ? ARCTAN_STEPS : TABLE_LEN;
  localparam int unsigned ITER_W       = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam int unsigned TAB_IDX_W    = 5;
  localparam int unsigned TAB_W        = 22;

  localparam int unsigned CX_W   = 35;  // cordic x/y datapath
  localparam int unsigned CZ_W   = 25;  // cordic angle accumulator
  localparam int unsigned ZCL_W  = 23;  // clamped magnitude
  localparam int unsigned MA_W   = 34;  // multiplier operand a
  localparam int unsigned MB_W   = 18;  // multiplier operand b
  localparam int unsigned PROD_W = MA_W + MB_W;

  localparam logic [ZCL_W-1:0] NINETY_DEG  = ZCL_W'(5898240);
  localparam logic [15:0]      SAMPLE_PERIOD_RST = 16'd6554;
  localparam logic [15:0]      GYRO_WEIGHT_RST   = 16'd62259;
  localparam logic [16:0]      ONE_Q16     = 17'h10000;
  localparam logic [PROD_W:0]  ROUND_HALF  = (PROD_W+1)'(32768);

  typedef enum logic {
    REG_SAMPLE_PERIOD = 1'b0,
    REG_GYRO_WEIGHT   = 1'b1
  } reg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_ITER,
    S_ANGLE,
    S_MSTEP,
    S_GYRO,
    S_MGW,
    S_MTW,
    S_SUM
  } state_e;

  function automatic logic [TAB_W-1:0] atan_deg(input logic [TAB_IDX_W-1:0] idx);
    logic [TAB_W-1:0] v;
    case (idx)
      5'd0:    v = TAB_W'(2949120);
      5'd1:    v = TAB_W'(1740967);
      5'd2:    v = TAB_W'(919879);
      5'd3:    v = TAB_W'(466945);
      5'd4:    v = TAB_W'(234379);
      5'd5:    v = TAB_W'(117304);
      5'd6:    v = TAB_W'(58666);
      5'd7:    v = TAB_W'(29335);
      5'd8:    v = TAB_W'(14668);
      5'd9:    v = TAB_W'(7334);
      5'd10:   v = TAB_W'(3667);
      5'd11:   v = TAB_W'(1833);
      5'd12:   v = TAB_W'(917);
      5'd13:   v = TAB_W'(458);
      5'd14:   v = TAB_W'(229);
      5'd15:   v = TAB_W'(115);
      5'd16:   v = TAB_W'(57);
      5'd17:   v = TAB_W'(29);
      5'd18:   v = TAB_W'(14);
      5'd19:   v = TAB_W'(7);
      5'd20:   v = TAB_W'(4);
      5'd21:   v = TAB_W'(2);
      5'd22:   v = TAB_W'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

FILE: src/complementary_tilt_filter_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Complementary tilt filter
// Each input beat runs two arctangents on the shared CORDIC unit (load,
// iterate and angle for each axis), then six products on the shared multiplier
// (two axes); the result then waits in S_SUM until the output is free. A new
// beat is taken only in S_IDLE, once the previous result has been registered.
// Reset: asynchronous, active low; angles clear to zero, dt to 0.1 s, w 0.95.
// ----------------------------------------------------------------------------
// Fuses accelerometer tilt (CORDIC arctangent) with integrated gyro rates.
// ----------------------------------------------------------------------------
module complementary_tilt_filter_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic signed [15:0] accel_x_i,
  input  wire logic signed [15:0] accel_y_i,
  input  wire logic signed [15:0] accel_z_i,
  input  wire logic signed [31:0] rate_x_i,
  input  wire logic signed [31:0] rate_y_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic signed [31:0] pitch_angle_o,
  output logic signed [31:0] bank_angle_o
);

  localparam int unsigned CX_W   = ctf_pkg::CX_W;
  localparam int unsigned CZ_W   = ctf_pkg::CZ_W;
  localparam int unsigned ZCL_W  = ctf_pkg::ZCL_W;
  localparam int unsigned MA_W   = ctf_pkg::MA_W;
  localparam int unsigned MB_W   = ctf_pkg::MB_W;
  localparam int unsigned PROD_W = ctf_pkg::PROD_W;
  localparam int unsigned ITER_W = ctf_pkg::ITER_W;

  ctf_pkg::state_e state_q, state_d;

  logic [15:0] dt_q, w_q;
  logic        sel_q;
  logic [ITER_W-1:0] iter_q;

  logic signed [15:0] ax_q, ay_q, az_q;
  logic signed [31:0] rx_q, ry_q;

  logic signed [CX_W-1:0] cx_q, cy_q;
  logic signed [CZ_W-1:0] cz_q;

  logic signed [31:0] fused_pitch_q, fused_bank_q, tilt_pitch_q, tilt_bank_q;
  logic signed [PROD_W-1:0] prod_q, acc_q;
  logic signed [MA_W-1:0]   gyro_q;

  logic               out_valid_q;
  logic signed [31:0] pitch_out_q, bank_out_q;

  // control decode
  logic iter_last, out_free, accept_in;

  // arctangent operands
  logic signed [15:0] num;
  logic signed [16:0] num_x, den_x, an_x, ad_x;
  logic               az_nz, neg;

  // cordic step
  logic signed [CX_W-1:0] sx, sy;
  logic signed [CZ_W-1:0] tab;

  // angle finalize
  logic [ZCL_W-1:0]   zcl;
  logic signed [31:0] tilt_new;

  // blend datapath
  logic signed [31:0]     angle_sel, rate_sel, tilt_sel;
  logic signed [MA_W-1:0] mul_a;
  logic signed [MB_W-1:0] mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W:0]   step_r, sum_r;
  logic signed [PROD_W-16:0] sum_sh;
  logic signed [31:0]       blend_res;

  assign iter_last = (iter_q == ITER_W'(ctf_pkg::CORDIC_STEPS - 1));
  assign out_free  = !out_valid_q || out_ready_i;
  assign accept_in = in_valid_i && in_ready_o;

  // ---------------- arctangent operands ----------------
  assign num   = sel_q ? ay_q : ax_q;
  assign num_x = {num[15], num};
  assign den_x = -{az_q[15], az_q};
  assign an_x  = num_x[16] ? -num_x : num_x;
  assign ad_x  = den_x[16] ? -den_x : den_x;
  assign az_nz = (az_q != '0);
  assign neg   = (num_x[16] ^ den_x[16]) ^ sel_q;

  // ---------------- cordic step ----------------
  assign sx  = cx_q >>> iter_q;
  assign sy  = cy_q >>> iter_q;
  assign tab = $signed({{(CZ_W-ctf_pkg::TAB_W){1'b0}},
                        ctf_pkg::atan_deg(ctf_pkg::TAB_IDX_W'(iter_q))});

  // ---------------- angle finalize ----------------
  always_comb begin
    if (cz_q[CZ_W-1]) begin
      zcl = '0;
    end else if (cz_q > $signed({{(CZ_W-ZCL_W){1'b0}}, ctf_pkg::NINETY_DEG})) begin
      zcl = ctf_pkg::NINETY_DEG;
    end else begin
      zcl = cz_q[ZCL_W-1:0];
    end
    if (num == '0) begin
      tilt_new = '0;
    end else if (neg) begin
      tilt_new = -$signed({{(32-ZCL_W){1'b0}}, zcl});
    end else begin
      tilt_new = $signed({{(32-ZCL_W){1'b0}}, zcl});
    end
  end

  // ---------------- shared multiplier ----------------
  assign angle_sel = sel_q ? fused_bank_q : fused_pitch_q;
  assign rate_sel  = sel_q ? rx_q : ry_q;
  assign tilt_sel  = sel_q ? tilt_bank_q : tilt_pitch_q;

  always_comb begin
    case (state_q)
      ctf_pkg::S_MGW: begin
        mul_a = gyro_q;
        mul_b = $signed({2'b00, w_q});
      end
      ctf_pkg::S_MTW: begin
        mul_a = MA_W'(tilt_sel);
        mul_b = $signed({1'b0, 17'(ctf_pkg::ONE_Q16 - {1'b0, w_q})});
      end
      default: begin
        mul_a = MA_W'(rate_sel);
        mul_b = $signed({2'b00, dt_q});
      end
    endcase
  end

  assign prod   = mul_a * mul_b;
  assign step_r = $signed({prod_q[PROD_W-1], prod_q}) + $signed(ctf_pkg::ROUND_HALF);
  assign sum_r  = $signed({acc_q[PROD_W-1], acc_q}) + $signed({prod_q[PROD_W-1], prod_q})
                + $signed(ctf_pkg::ROUND_HALF);
  assign sum_sh = sum_r[PROD_W:16];

  always_comb begin
    if (sum_sh > $signed((PROD_W-15)'(32'sh7FFF_FFFF))) begin
      blend_res = 32'sh7FFF_FFFF;
    end else if (sum_sh < -$signed((PROD_W-15)'(33'sh0_8000_0000))) begin
      blend_res = 32'sh8000_0000;
    end else begin
      blend_res = sum_sh[31:0];
    end
  end

  // ---------------- sequencer ----------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ctf_pkg::S_IDLE:  if (in_valid_i) state_d = ctf_pkg::S_LOAD;
      ctf_pkg::S_LOAD:  state_d = ctf_pkg::S_ITER;
      ctf_pkg::S_ITER:  if (iter_last) state_d = ctf_pkg::S_ANGLE;
      ctf_pkg::S_ANGLE: state_d = sel_q ? ctf_pkg::S_MSTEP : ctf_pkg::S_LOAD;
      ctf_pkg::S_MSTEP: state_d = ctf_pkg::S_GYRO;
      ctf_pkg::S_GYRO:  state_d = ctf_pkg::S_MGW;
      ctf_pkg::S_MGW:   state_d = ctf_pkg::S_MTW;
      ctf_pkg::S_MTW:   state_d = ctf_pkg::S_SUM;
      ctf_pkg::S_SUM: begin
        if (!sel_q) begin
          state_d = ctf_pkg::S_MSTEP;
        end else if (out_free) begin
          state_d = ctf_pkg::S_IDLE;
        end
      end
      default: state_d = ctf_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = (state_q == ctf_pkg::S_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ctf_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ---------------- configuration ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dt_q <= ctf_pkg::SAMPLE_PERIOD_RST;
      w_q  <= ctf_pkg::GYRO_WEIGHT_RST;
    end else if (cfg_we_i) begin
      case (ctf_pkg::reg_idx_e'(cfg_idx_i))
        ctf_pkg::REG_SAMPLE_PERIOD: dt_q <= cfg_data_i;
        ctf_pkg::REG_GYRO_WEIGHT:   w_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------- control and state ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q         <= 1'b0;
      iter_q        <= '0;
      fused_pitch_q <= '0;
      fused_bank_q  <= '0;
      tilt_pitch_q  <= '0;
      tilt_bank_q   <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i &&
          !(state_q == ctf_pkg::S_SUM && sel_q)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ctf_pkg::S_IDLE: begin
          sel_q <= 1'b0;
        end
        ctf_pkg::S_LOAD: begin
          iter_q <= '0;
        end
        ctf_pkg::S_ITER: begin
          iter_q <= iter_q + ITER_W'(1);
        end
        ctf_pkg::S_ANGLE: begin
          if (az_nz) begin
            if (sel_q) begin
              tilt_bank_q <= tilt_new;
            end else begin
              tilt_pitch_q <= tilt_new;
            end
          end
          sel_q <= !sel_q;
        end
        ctf_pkg::S_SUM: begin
          if (!sel_q) begin
            fused_pitch_q <= blend_res;
            sel_q         <= 1'b1;
          end else if (out_free) begin
            fused_bank_q <= blend_res;
            out_valid_q  <= 1'b1;
            sel_q        <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // ---------------- datapath ----------------
  always_ff @(posedge clk_i) begin
    if (accept_in) begin
      ax_q <= accel_x_i;
      ay_q <= accel_y_i;
      az_q <= accel_z_i;
      rx_q <= rate_x_i;
      ry_q <= rate_y_i;
    end
    case (state_q)
      ctf_pkg::S_LOAD: begin
        cx_q <= $signed({3'b000, ad_x[15:0], 16'h0000});
        cy_q <= $signed({3'b000, an_x[15:0], 16'h0000});
        cz_q <= '0;
      end
      ctf_pkg::S_ITER: begin
        if (!cy_q[CX_W-1]) begin
          cx_q <= cx_q + sy;
          cy_q <= cy_q - sx;
          cz_q <= cz_q + tab;
        end else begin
          cx_q <= cx_q - sy;
          cy_q <= cy_q + sx;
          cz_q <= cz_q - tab;
        end
      end
      ctf_pkg::S_MSTEP: prod_q <= prod;
      ctf_pkg::S_GYRO:  gyro_q <= MA_W'(angle_sel) + step_r[MA_W+15:16];
      ctf_pkg::S_MGW:   acc_q  <= prod;
      ctf_pkg::S_MTW:   prod_q <= prod;
      ctf_pkg::S_SUM: begin
        if (sel_q && out_free) begin
          pitch_out_q <= fused_pitch_q;
          bank_out_q  <= blend_res;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o   = out_valid_q;
  assign pitch_angle_o = pitch_out_q;
  assign bank_angle_o  = bank_out_q;

endmodule
`default_nettype wire

FILE: src/ctf_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Complementary tilt filter port checker
// Watches the top level ports for handshake and sequencing slips.
// ----------------------------------------------------------------------------
module ctf_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [31:0] pitch_angle_o,
  input wire logic [31:0] bank_angle_o
);

  a_busy_after_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o ##1 !in_ready_o)
    else $error("input taken again too soon");

  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !$rose(out_valid_o))
    else $error("result raised right after input beat");

  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_ready_o))
    else $error("result appeared without work in progress");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(pitch_angle_o) && $stable(bank_angle_o)))
    else $error("stalled result changed");

endmodule

bind complementary_tilt_filter_top ctf_checker u_ctf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .pitch_angle_o (pitch_angle_o),
  .bank_angle_o  (bank_angle_o)
);
`default_nettype wire
